// ===== rtl/core/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and constants for the bounded set table: request codes,
// status codes and the command word that is broadcast to the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package bst_pkg;

    // Field widths fixed by the interface
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 3;
    localparam int INDEX_W   = 8;
    localparam int STATUS_W  = 3;
    localparam int POS_W     = 5;
    localparam int COUNT_W   = 6;
    // Widest internal count (capacity up to 256 needs 9 bits)
    localparam int CNT_MAX_W = 9;

    // Request codes
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD  = 3'd0,
        MODE_DEL  = 3'd1,
        MODE_FIND = 3'd2,
        MODE_READ = 3'd3,
        MODE_POP  = 3'd4
    } t_mode;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_PRESENT = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISSING = 3'd3,
        ST_RANGE   = 3'd4,
        ST_EMPTY   = 3'd5
    } t_status;

    // Command broadcast to every cell
    typedef struct packed {
        logic [DATA_W-1:0]  value;   // key to compare or to append
        logic [INDEX_W-1:0] index;   // read position
        logic               cmp_en;  // capture match and read data
        logic               add_en;  // append value at the tail cell
        logic               del_en;  // close the gap behind the match
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/bounded_set_table.sv =====
// ----------------------------------------------------------------------------
// bounded_set_table
// Set of distinct signed 32-bit values in insertion order, up to CAPACITY.
// ----------------------------------------------------------------------------
// A request goes from acceptance to a loaded result through S_IDLE, where
// it is registered; S_CMP, where every cell compares its entry with the key
// and registers its match flag and read data; and S_APPLY, where the flags
// are combined, the status is decided and the cells append or shift down
// along the chain. One request is in flight at a time, so no new request is
// taken until the last has left S_APPLY; the result register lets the next
// request enter while a result still waits downstream. Entries hold no reset
// value: only slots below the count are ever looked at.
`default_nettype none

module bounded_set_table #(
    parameter int CAPACITY = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [bst_pkg::MODE_W-1:0]   i_mode,
    input  wire logic signed [bst_pkg::DATA_W-1:0] i_value,
    input  wire logic [bst_pkg::INDEX_W-1:0]  i_index,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [bst_pkg::STATUS_W-1:0]      o_status,
    output logic signed [bst_pkg::DATA_W-1:0] o_read_value,
    output logic [bst_pkg::POS_W-1:0]         o_position,
    output logic [bst_pkg::COUNT_W-1:0]       o_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [bst_pkg::MODE_W-1:0]  r_mode;
    logic [bst_pkg::DATA_W-1:0]  r_value;
    logic [bst_pkg::INDEX_W-1:0] r_index;
    logic [CW-1:0]               r_count, n_count;

    logic                          r_out_valid;
    logic [bst_pkg::STATUS_W-1:0]  r_out_status;
    logic [bst_pkg::DATA_W-1:0]    r_out_rd;
    logic [bst_pkg::POS_W-1:0]     r_out_pos;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_apply;
    bst_pkg::t_cell_cmd            w_cmd;
    bst_pkg::t_status              w_status;
    logic                          w_add_ok;
    logic                          w_del_ok;
    logic [bst_pkg::DATA_W-1:0]    w_rd;
    logic [bst_pkg::INDEX_W-1:0]   w_pos;
    logic                          w_found;

    logic [bst_pkg::DATA_W-1:0]    w_entry_rd [CAPACITY];
    logic                          w_match    [CAPACITY];
    logic [bst_pkg::DATA_W-1:0]    w_next     [CAPACITY];
    logic                          w_shift    [CAPACITY+1];
    logic [bst_pkg::DATA_W-1:0]    w_cell_val [CAPACITY];

    // handshake
    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_apply    = (r_state == S_APPLY) && w_out_free;

    // request register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= i_mode;
            r_value <= i_value;
            r_index <= i_index;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_CMP;
            S_CMP:   n_state = S_APPLY;
            S_APPLY: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // combine per-cell flags; at most one live cell matches
    always_comb begin
        w_found = 1'b0;
        w_pos   = '0;
        w_rd    = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_found = w_found | w_match[k];
            w_pos   = w_pos | (w_match[k] ? bst_pkg::INDEX_W'(k) : '0);
            w_rd    = w_rd | w_entry_rd[k];
        end
    end

    // status decision and count update
    always_comb begin
        w_status = bst_pkg::ST_OK;
        w_add_ok = 1'b0;
        w_del_ok = 1'b0;
        n_count  = r_count;
        case (r_mode)
            bst_pkg::MODE_ADD: begin
                if (w_found) begin
                    w_status = bst_pkg::ST_PRESENT;
                end else if (r_count >= CapCount) begin
                    w_status = bst_pkg::ST_FULL;
                end else begin
                    w_add_ok = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            bst_pkg::MODE_DEL: begin
                if (!w_found) begin
                    w_status = bst_pkg::ST_MISSING;
                end else begin
                    w_del_ok = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            bst_pkg::MODE_FIND: begin
                if (!w_found) w_status = bst_pkg::ST_MISSING;
            end
            bst_pkg::MODE_READ: begin
                if ({1'b0, r_index} >= (bst_pkg::INDEX_W+1)'(r_count)) begin
                    w_status = bst_pkg::ST_RANGE;
                end
            end
            bst_pkg::MODE_POP: begin
                if (r_count == '0) begin
                    w_status = bst_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            default: w_status = bst_pkg::ST_OK;
        endcase
    end

    // command broadcast to the chain
    always_comb begin
        w_cmd.value  = r_value;
        w_cmd.index  = r_index;
        w_cmd.cmp_en = (r_state == S_CMP);
        w_cmd.add_en = w_apply && w_add_ok;
        w_cmd.del_en = w_apply && w_del_ok;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_out_status <= w_status;
            r_out_rd     <= ((r_mode == bst_pkg::MODE_READ)
                             && (w_status == bst_pkg::ST_OK)) ? w_rd : '0;
            r_out_pos    <= ((r_mode == bst_pkg::MODE_FIND) && w_found)
                            ? w_pos[bst_pkg::POS_W-1:0] : '0;
        end
    end

    // count output: low bits of the live count
    logic [bst_pkg::CNT_MAX_W-1:0] w_count_ext;
    assign w_count_ext = bst_pkg::CNT_MAX_W'(r_count);

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_rd;
    assign o_position   = r_out_pos;
    assign o_count      = w_count_ext[bst_pkg::COUNT_W-1:0];

    // cell chain
    assign w_shift[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == CAPACITY - 1) begin : g_tail
            assign w_next[g] = w_cell_val[g];
        end else begin : g_body
            assign w_next[g] = w_cell_val[g+1];
        end

        bst_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_count      (r_count),
            .i_next_entry (w_next[g]),
            .i_shift      (w_shift[g]),
            .o_shift      (w_shift[g+1]),
            .o_match      (w_match[g]),
            .o_read_data  (w_entry_rd[g]),
            .o_entry      (w_cell_val[g])
        );
    end

endmodule

`default_nettype wire

// ===== rtl/core/bst_cell.sv =====
// ----------------------------------------------------------------------------
// bst_cell
// One slot of the set. Holds one entry, compares it against the broadcast
// key, and on delete takes its right neighbor's entry once the shift token
// coming down the chain (or its own match) says the gap lies at or before it.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  wire logic                       i_clk,
    input  wire bst_pkg::t_cell_cmd         i_cmd,
    input  wire logic [CW-1:0]              i_count,
    input  wire logic [bst_pkg::DATA_W-1:0] i_next_entry,
    input  wire logic                       i_shift,
    output logic                            o_shift,
    output logic                            o_match,
    output logic [bst_pkg::DATA_W-1:0]      o_read_data,
    output logic [bst_pkg::DATA_W-1:0]      o_entry
);

    localparam logic [CW-1:0]               CellIdx  = CW'(IDX);
    localparam logic [bst_pkg::INDEX_W-1:0] CellIdx8 = bst_pkg::INDEX_W'(IDX);

    logic [bst_pkg::DATA_W-1:0] r_entry;
    logic                       r_match;
    logic [bst_pkg::DATA_W-1:0] r_read_data;
    logic                       w_live;

    // slot holds a stored element
    assign w_live  = (CellIdx < i_count);
    // gap lies here or earlier in the chain
    assign o_shift = i_shift | r_match;

    // compare stage: match flag and gated read data
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_en) begin
            r_match     <= w_live && (r_entry == i_cmd.value);
            r_read_data <= (w_live && (i_cmd.index == CellIdx8)) ? r_entry
                                                                 : '0;
        end
    end

    // update stage: append at tail or shift down behind a deleted entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_en && (i_count == CellIdx)) begin
            r_entry <= i_cmd.value;
        end else if (i_cmd.del_en && o_shift) begin
            r_entry <= i_next_entry;
        end
    end

    assign o_match     = r_match;
    assign o_read_data = r_read_data;
    // stored entry, handed to the left neighbor for shifting
    assign o_entry     = r_entry;

endmodule

`default_nettype wire

// ===== sim/bounded_set_table_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_set_table_tb
// Self-checking bench for the bounded set table. A directed table covers reset state,
// value extremes, duplicates, misses, range errors, the empty pop and the spare
// request codes. Random fill, mix and drain phases then push the set to full and
// back to empty repeatedly. Responses are checked against a software copy of the set,
// typed directed rows against hand-written values. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module bounded_set_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bst_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 12;
    localparam int RANDOM_ITEMS = 1450;
    localparam int PHASE_LEN    = 80;
    localparam int PAUSE_PHASE  = 9;     // sender waits for an empty pipe here
    localparam int HOLD_AFTER   = 500;   // responses before the long back-pressure
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 20;

    // Request codes the block ignores
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   read_value;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  count;
    } set_result_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [DATA_W-1:0]  value;
        logic [INDEX_W-1:0] index;
        logic               typed;   // 1: use the hand-written response below
        set_result_t        want;
    } dir_row_t;

    typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // empty set after reset
        '{MODE_READ, 32'h0000_0000, 8'd0,   1'b1, '{ST_RANGE,   32'h0, 5'd0, 6'd0}},
        '{MODE_POP,  32'h0000_0000, 8'd0,   1'b1, '{ST_EMPTY,   32'h0, 5'd0, 6'd0}},
        '{MODE_DEL,  32'h0000_0005, 8'd0,   1'b1, '{ST_MISSING, 32'h0, 5'd0, 6'd0}},
        '{MODE_FIND, 32'h0000_0005, 8'd0,   1'b1, '{ST_MISSING, 32'h0, 5'd0, 6'd0}},
        // extremes, duplicate add
        '{MODE_ADD,  32'h8000_0000, 8'd0,   1'b1, '{ST_OK,      32'h0, 5'd0, 6'd1}},
        '{MODE_ADD,  32'h7FFF_FFFF, 8'd0,   1'b1, '{ST_OK,      32'h0, 5'd0, 6'd2}},
        '{MODE_ADD,  32'h8000_0000, 8'd0,   1'b1, '{ST_PRESENT, 32'h0, 5'd0, 6'd2}},
        '{MODE_ADD,  32'h0000_0000, 8'd0,   1'b1, '{ST_OK,      32'h0, 5'd0, 6'd3}},
        '{MODE_ADD,  32'hFFFF_FFFF, 8'd0,   1'b1, '{ST_OK,      32'h0, 5'd0, 6'd4}},
        '{MODE_FIND, 32'h7FFF_FFFF, 8'd0,   1'b1, '{ST_OK,      32'h0, 5'd1, 6'd4}},
        '{MODE_READ, 32'h0000_0000, 8'd3,   1'b1,
          '{ST_OK, 32'hFFFF_FFFF, 5'd0, 6'd4}},
        '{MODE_READ, 32'h0000_0000, 8'd255, 1'b1, '{ST_RANGE,   32'h0, 5'd0, 6'd4}},
        '{MODE_READ, 32'h0000_0000, 8'd4,   1'b1, '{ST_RANGE,   32'h0, 5'd0, 6'd4}},
        // delete in the middle, then look behind the gap
        '{MODE_DEL,  32'h7FFF_FFFF, 8'd0,   1'b0, '0},
        '{MODE_READ, 32'h0000_0000, 8'd1,   1'b0, '0},
        '{MODE_READ, 32'h0000_0000, 8'd2,   1'b0, '0},
        '{MODE_FIND, 32'hFFFF_FFFF, 8'd0,   1'b0, '0},
        // spare codes leave the set alone
        '{MODE_SPARE_5, 32'hAAAA_AAAA, 8'hAA, 1'b1, '{ST_OK, 32'h0, 5'd0, 6'd3}},
        '{MODE_SPARE_7, 32'h5555_5555, 8'h55, 1'b1, '{ST_OK, 32'h0, 5'd0, 6'd3}},
        '{MODE_SPARE_6, 32'h0000_0001, 8'd1,  1'b0, '0},
        // delete the head, pop, delete the last one
        '{MODE_DEL,  32'h8000_0000, 8'd0,   1'b0, '0},
        '{MODE_POP,  32'h0000_0000, 8'd0,   1'b0, '0},
        '{MODE_DEL,  32'h0000_0000, 8'd0,   1'b0, '0},
        '{MODE_POP,  32'h0000_0000, 8'd0,   1'b1, '{ST_EMPTY,   32'h0, 5'd0, 6'd0}},
        '{MODE_ADD,  32'h1234_5678, 8'd0,   1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    logic [MODE_W-1:0] req_mode = '0;
    logic signed [DATA_W-1:0] req_value = '0;
    logic [INDEX_W-1:0] req_index = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    logic [STATUS_W-1:0] rsp_status;
    logic signed [DATA_W-1:0] rsp_read_value;
    logic [POS_W-1:0] rsp_position;
    logic [COUNT_W-1:0] rsp_count;

    // Software copy of the set
    logic [DATA_W-1:0] stored_vals [CAPACITY];
    int stored_cnt = 0;

    set_result_t pending_results [$];
    int n_errors = 0;
    int n_checked = 0;
    bit snd_calm = 1'b0;

    always #CLK_HALF clk = ~clk;

    bounded_set_table #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (req_valid),
        .o_ready      (req_ready),
        .i_mode       (req_mode),
        .i_value      (req_value),
        .i_index      (req_index),
        .o_valid      (rsp_valid),
        .i_ready      (rsp_ready),
        .o_status     (rsp_status),
        .o_read_value (rsp_read_value),
        .o_position   (rsp_position),
        .o_count      (rsp_count)
    );

    // Slot of v among the stored entries, -1 when absent
    function automatic int find_slot(logic [DATA_W-1:0] v);
        for (int k = 0; k < stored_cnt; k++) begin
            if (stored_vals[k] == v) return k;
        end
        return -1;
    endfunction

    // Apply one request to the software set and return its response
    function automatic set_result_t apply_set_op(logic [MODE_W-1:0] m,
                                                 logic [DATA_W-1:0] v,
                                                 logic [INDEX_W-1:0] x);
        set_result_t res;
        int slot;
        res = '0;
        res.status = ST_OK;
        slot = find_slot(v);
        case (m)
            MODE_ADD: begin
                if (slot >= 0) begin
                    res.status = ST_PRESENT;
                end else if (stored_cnt >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    stored_vals[stored_cnt] = v;
                    stored_cnt++;
                end
            end
            MODE_DEL: begin
                if (slot < 0) begin
                    res.status = ST_MISSING;
                end else begin
                    for (int k = slot; k + 1 < stored_cnt; k++)
                        stored_vals[k] = stored_vals[k + 1];
                    stored_cnt--;
                end
            end
            MODE_FIND: begin
                if (slot < 0) res.status = ST_MISSING;
                else res.position = POS_W'(slot);
            end
            MODE_READ: begin
                if (int'(x) >= stored_cnt) res.status = ST_RANGE;
                else res.read_value = stored_vals[x];
            end
            MODE_POP: begin
                if (stored_cnt == 0) res.status = ST_EMPTY;
                else stored_cnt--;
            end
            default: ;
        endcase
        res.count = COUNT_W'(stored_cnt);
        return res;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(phase_t ph);
        int r;
        int w_add, w_del, w_find, w_read, w_pop;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL: begin
                w_add = 70; w_del = 5;  w_find = 10; w_read = 10; w_pop = 3;
            end
            PH_MIX: begin
                w_add = 30; w_del = 20; w_find = 15; w_read = 20; w_pop = 10;
            end
            default: begin
                w_add = 10; w_del = 40; w_find = 10; w_read = 10; w_pop = 25;
            end
        endcase
        if (r < w_add) return MODE_ADD;
        r -= w_add;
        if (r < w_del) return MODE_DEL;
        r -= w_del;
        if (r < w_find) return MODE_FIND;
        r -= w_find;
        if (r < w_read) return MODE_READ;
        r -= w_read;
        if (r < w_pop) return MODE_POP;
        return MODE_W'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
    endfunction

    // Keys: stored ones for hits, a small pool for collisions, wide randoms
    function automatic logic [DATA_W-1:0] pick_value(logic [MODE_W-1:0] m);
        int r;
        int hit_pct;
        r = $urandom_range(0, 99);
        hit_pct = (m == MODE_ADD) ? 15 : 65;
        if (m != MODE_ADD && m != MODE_DEL && m != MODE_FIND) return $urandom();
        if (r < hit_pct && stored_cnt > 0)
            return stored_vals[$urandom_range(0, stored_cnt - 1)];
        if (r < hit_pct + 30) return DATA_W'(int'($urandom_range(0, 95)) - 48);
        return $urandom();
    endfunction

    // Drive one request, wait for the handshake, then log its response
    task automatic offer_request(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] v,
                                 input logic [INDEX_W-1:0] x, input logic typed,
                                 input set_result_t want);
        int gap;
        set_result_t pred;
        gap = (snd_calm || $urandom_range(0, 99) < 50) ? 0 : gap_len();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_mode  <= m;
        req_value <= v;
        req_index <= x;
        do @(posedge clk); while (!req_ready);
        pred = apply_set_op(m, v, x);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic cmp_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endtask

    // Response side: check each response, random back-pressure
    initial begin
        set_result_t want;
        int stall_left;
        int rcv_cycle;
        bit rcv_calm;
        bit hold_done;
        stall_left = 0;
        rcv_cycle = 0;
        rcv_calm = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready) begin
                if (pending_results.size() == 0) begin
                    $error("response with no request outstanding");
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    cmp_field("status", want.status, rsp_status);
                    cmp_field("read_value", want.read_value, rsp_read_value);
                    cmp_field("position", want.position, rsp_position);
                    cmp_field("count", want.count, rsp_count);
                end
                n_checked++;
            end
            rcv_cycle++;
            if (rcv_cycle % 256 == 0) rcv_calm = ($urandom_range(0, 3) == 0);
            if (stall_left > 0) begin
                stall_left--;
            end else if (!hold_done && n_checked >= HOLD_AFTER) begin
                // long back-pressure so the block fills and blocks its input
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (!rcv_calm && $urandom_range(0, 99) < 25) begin
                stall_left = gap_len();
            end
            rsp_ready <= (stall_left == 0);
        end
    end

    // Watchdog on cycles without any handshake
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
                idle = 0;
            end else begin
                idle++;
                if (idle >= IDLE_LIMIT) begin
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // Request side: directed table, then random phases
    initial begin
        logic [MODE_W-1:0]  m;
        logic [DATA_W-1:0]  v;
        logic [INDEX_W-1:0] x;
        phase_t ph;
        int n_real;
        int phase_no;
        n_real = 0;
        phase_no = 0;

        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            offer_request(DIRECTED[r].mode, DIRECTED[r].value, DIRECTED[r].index,
                          DIRECTED[r].typed, DIRECTED[r].want);
        end

        while (n_real < RANDOM_ITEMS) begin
            case (phase_no % 3)
                0: ph = PH_FILL;
                1: ph = PH_MIX;
                default: ph = PH_DRAIN;
            endcase
            snd_calm = ($urandom_range(0, 3) == 0);
            if (phase_no == PAUSE_PHASE) begin
                // let the pipe run dry before going on
                req_valid <= 1'b0;
                do @(posedge clk); while (pending_results.size() != 0);
            end
            repeat (PHASE_LEN) begin
                m = pick_mode(ph);
                v = pick_value(m);
                if (m == MODE_READ && $urandom_range(0, 3) != 0)
                    x = INDEX_W'($urandom_range(0, stored_cnt));
                else
                    x = INDEX_W'($urandom_range(0, 255));
                offer_request(m, v, x, 1'b0, '0);
                if (m <= MODE_POP) n_real++;
            end
            phase_no++;
        end

        req_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bst_pkg.sv
rtl/core/bst_cell.sv
rtl/core/bounded_set_table.sv
sim/bounded_set_table_tb.sv
